@@ hdl/lrfd_pkg.sv @@
// Shared types, constants and helper functions for the longest-run block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package lrfd_pkg;

  localparam int RUN_W       = 11;
  localparam int CFG_W       = 11;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [RUN_W-1:0] RUN_MAX    = 11'h7FF;
  localparam logic [CFG_W-1:0] GRID_RESET = 11'd1024;

  typedef enum logic [1:0] {
    WIN_TIE   = 2'd0,
    WIN_SMALL = 2'd1,
    WIN_BIG   = 2'd2
  } winner_e;

  // One neighbor seen by a run cell: its pixel and the run that ends there.
  typedef struct packed {
    logic             pix;
    logic [RUN_W-1:0] run;
  } run_t;

  // One line buffer entry: pixel and the three runs that continue downward.
  typedef struct packed {
    logic             pix;
    logic [RUN_W-1:0] vert;
    logic [RUN_W-1:0] diag;
    logic [RUN_W-1:0] anti;
  } line_t;

  typedef struct packed {
    winner_e          winner;
    logic [RUN_W-1:0] longest;
  } result_t;

  // Run extension with saturation at the largest representable length.
  function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] run);
    logic [RUN_W-1:0] res;
    res = (run == RUN_MAX) ? RUN_MAX : run + RUN_W'(1);
    return res;
  endfunction

endpackage

@@ hdl/lrfd_cell.sv @@
// One run cell: extends the run of a neighbor pixel when the classes match.
// Depends on lrfd_pkg for the run type and the saturating increment.
module lrfd_cell (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic                      en_i,
  input  logic                      pixel_i,
  input  lrfd_pkg::run_t            nb_i,
  output logic [lrfd_pkg::RUN_W-1:0] run_o,
  output lrfd_pkg::run_t            q_o
);

  lrfd_pkg::run_t q_q;

  // A masked neighbor (outside the image or in the first row) starts a new run.
  assign run_o = (en_i && (nb_i.pix == pixel_i)) ? lrfd_pkg::bump(nb_i.run)
                                                 : lrfd_pkg::RUN_W'(1);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      q_q.pix <= pixel_i;
      q_q.run <= run_o;
    end
  end

  assign q_o = q_q;

endmodule

@@ hdl/lrfd_line_buf.sv @@
// Line buffer holding the previous row: one write port, two registered read ports.
// Depends on lrfd_pkg for the entry type.
module lrfd_line_buf #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  lrfd_pkg::line_t          wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b_i,
  output lrfd_pkg::line_t          rd_data_a_o,
  output lrfd_pkg::line_t          rd_data_b_o
);

  lrfd_pkg::line_t mem_q [DEPTH];
  lrfd_pkg::line_t rd_a_q;
  lrfd_pkg::line_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // A read at the address written in the same cycle returns the old entry.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

@@ hdl/longest_run_four_directions_core.sv @@
// Top level of the longest-run block: column control, line buffer, run cells, result queue.
// Depends on lrfd_pkg, lrfd_cell and lrfd_line_buf.
//
//   channel  | direction | payload                                   | end marker
//   ---------+-----------+-------------------------------------------+-------------
//   s_axis   | in        | tdata[0] pixel_class                      | tlast = last
//   m_axis   | out       | tdata[1:0] winner, tdata[12:2] longest    | none
//   cfg      | in        | cfg_wdata_i = grid_side                   | none
//
// One pixel request is taken every clock while the result queue has room; a
// pixel passes the registered line buffer read, the run cell stage and the
// per-class maximum stage before its image result enters the result queue.
// Input ready drops only while two image results are in flight or queued, so
// a stream of back-to-back single-pixel images is held off at times.
// Reset (rst_ni low, asynchronous) empties the pipeline and the queue, sets
// grid_side to 1024 and starts a new image; the line buffer is not cleared,
// since the first-row flag masks every entry that was not yet written.
module longest_run_four_directions_core #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration: grid_side, written when cfg_we_i is high.
  input  logic                               cfg_we_i,
  input  logic [lrfd_pkg::CFG_W-1:0]         cfg_wdata_i,
  // Pixel stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lrfd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [0] pixel_class, rest zero
  input  logic                               s_axis_tlast,   // last_pixel
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lrfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // [1:0] winner, [12:2] longest_run
);

  localparam int AW   = $clog2(MAX_SIDE);
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CMPW = (SW > lrfd_pkg::CFG_W) ? SW : lrfd_pkg::CFG_W;
  localparam int RW   = lrfd_pkg::RUN_W;

  // ---------------------------------------------------------------------------
  // Configuration register and effective side.
  // ---------------------------------------------------------------------------
  logic [lrfd_pkg::CFG_W-1:0] grid_side_q;
  logic [CMPW-1:0]            side_raw;
  logic [CMPW-1:0]            side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= lrfd_pkg::GRID_RESET;
    end else if (cfg_we_i) begin
      grid_side_q <= cfg_wdata_i;
    end
  end

  // A side of zero acts as one; anything above the buffer depth acts as the depth.
  always_comb begin
    side_raw = CMPW'(grid_side_q);
    if (side_raw == '0) begin
      side = CMPW'(1);
    end else if (side_raw > CMPW'(MAX_SIDE)) begin
      side = CMPW'(MAX_SIDE);
    end else begin
      side = side_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: column tracking and line buffer read requests.
  // ---------------------------------------------------------------------------
  logic          accept;
  logic          pixel_a;
  logic [AW-1:0] col_q;
  logic          first_q;
  logic          wrap_a;
  logic [AW-1:0] col_a;
  logic          first_a;
  logic [CMPW-1:0] col_inc;
  logic          row_end_a;
  logic [AW-1:0] ur_addr_a;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign pixel_a = s_axis_tdata[0];

  // If the side shrank to the current column or below, this pixel opens the next row.
  always_comb begin
    wrap_a    = CMPW'(col_q) >= side;
    col_a     = wrap_a ? '0 : col_q;
    first_a   = first_q && !wrap_a;
    col_inc   = CMPW'(col_a) + CMPW'(1);
    row_end_a = col_inc >= side;
    ur_addr_a = col_inc[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else if (accept) begin
      if (s_axis_tlast) begin
        col_q   <= '0;
        first_q <= 1'b1;
      end else begin
        col_q   <= row_end_a ? '0 : ur_addr_a;
        first_q <= first_a && !row_end_a;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run stage: line buffer data arrives, the run cells work out four lengths.
  // ---------------------------------------------------------------------------
  logic            valid_b_q;
  logic            pixel_b_q;
  logic            last_b_q;
  logic [AW-1:0]   col_b_q;
  logic            first_b_q;
  logic            left_ok_b_q;
  logic            ur_ok_b_q;
  logic            fwd_above_b_q;
  logic            fwd_ur_b_q;
  lrfd_pkg::line_t fwd_data_b_q;
  lrfd_pkg::line_t rd_above;
  lrfd_pkg::line_t rd_ur;
  lrfd_pkg::line_t above;
  lrfd_pkg::line_t upper_right;
  lrfd_pkg::line_t wr_data;
  lrfd_pkg::run_t  upper_left_q;
  lrfd_pkg::run_t  nb_vert;
  lrfd_pkg::run_t  nb_anti;
  lrfd_pkg::run_t  h_q;
  lrfd_pkg::run_t  v_q;
  lrfd_pkg::run_t  d_q;
  lrfd_pkg::run_t  a_q;
  logic [RW-1:0]   run_h;
  logic [RW-1:0]   run_v;
  logic [RW-1:0]   run_d;
  logic [RW-1:0]   run_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else begin
      valid_b_q <= accept;
    end
  end

  // The entry written by the pixel now in the run stage is not yet visible to a
  // read issued at the same edge, so that case is bypassed from a copy of it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_b_q     <= pixel_a;
      last_b_q      <= s_axis_tlast;
      col_b_q       <= col_a;
      first_b_q     <= first_a;
      left_ok_b_q   <= col_a != '0;
      ur_ok_b_q     <= !row_end_a;
      fwd_above_b_q <= valid_b_q && (col_b_q == col_a);
      fwd_ur_b_q    <= valid_b_q && (col_b_q == ur_addr_a);
      fwd_data_b_q  <= wr_data;
    end
  end

  lrfd_line_buf #(
    .DEPTH (MAX_SIDE)
  ) u_line_buf (
    .clk_i       (clk_i),
    .wr_en_i     (valid_b_q),
    .wr_addr_i   (col_b_q),
    .wr_data_i   (wr_data),
    .rd_en_i     (accept),
    .rd_addr_a_i (col_a),
    .rd_addr_b_i (ur_addr_a),
    .rd_data_a_o (rd_above),
    .rd_data_b_o (rd_ur)
  );

  always_comb begin
    above       = fwd_above_b_q ? fwd_data_b_q : rd_above;
    upper_right = fwd_ur_b_q    ? fwd_data_b_q : rd_ur;
    nb_vert.pix = above.pix;
    nb_vert.run = above.vert;
    nb_anti.pix = upper_right.pix;
    nb_anti.run = upper_right.anti;
  end

  // The upper-left neighbor of the next pixel is the entry above this one,
  // taken before this pixel overwrites it.
  always_ff @(posedge clk_i) begin
    if (valid_b_q) begin
      upper_left_q.pix <= above.pix;
      upper_left_q.run <= above.diag;
    end
  end

  // Horizontal cell: its own stored output is the left neighbor.
  lrfd_cell u_cell_h (
    .clk_i   (clk_i),
    .load_i  (valid_b_q),
    .en_i    (left_ok_b_q),
    .pixel_i (pixel_b_q),
    .nb_i    (h_q),
    .run_o   (run_h),
    .q_o     (h_q)
  );

  lrfd_cell u_cell_v (
    .clk_i   (clk_i),
    .load_i  (valid_b_q),
    .en_i    (!first_b_q),
    .pixel_i (pixel_b_q),
    .nb_i    (nb_vert),
    .run_o   (run_v),
    .q_o     (v_q)
  );

  lrfd_cell u_cell_d (
    .clk_i   (clk_i),
    .load_i  (valid_b_q),
    .en_i    (!first_b_q && left_ok_b_q),
    .pixel_i (pixel_b_q),
    .nb_i    (upper_left_q),
    .run_o   (run_d),
    .q_o     (d_q)
  );

  lrfd_cell u_cell_a (
    .clk_i   (clk_i),
    .load_i  (valid_b_q),
    .en_i    (!first_b_q && ur_ok_b_q),
    .pixel_i (pixel_b_q),
    .nb_i    (nb_anti),
    .run_o   (run_a),
    .q_o     (a_q)
  );

  always_comb begin
    wr_data.pix  = pixel_b_q;
    wr_data.vert = run_v;
    wr_data.diag = run_d;
    wr_data.anti = run_a;
  end

  // ---------------------------------------------------------------------------
  // Maximum stage: per-class best lengths and the image result.
  // ---------------------------------------------------------------------------
  logic              valid_c_q;
  logic              last_c_q;
  logic [RW-1:0]     best_small_q;
  logic [RW-1:0]     best_big_q;
  logic [RW-1:0]     max_hv;
  logic [RW-1:0]     max_da;
  logic [RW-1:0]     max_all;
  logic [RW-1:0]     new_small;
  logic [RW-1:0]     new_big;
  lrfd_pkg::result_t result;
  logic              push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else begin
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_b_q) begin
      last_c_q <= last_b_q;
    end
  end

  // The cells still hold this pixel's runs and class (every cell stores the
  // current pixel), so the horizontal cell's copy of the pixel serves as the class.
  always_comb begin
    max_hv    = (h_q.run > v_q.run) ? h_q.run : v_q.run;
    max_da    = (d_q.run > a_q.run) ? d_q.run : a_q.run;
    max_all   = (max_hv > max_da) ? max_hv : max_da;
    new_small = (h_q.pix && (max_all > best_small_q)) ? max_all : best_small_q;
    new_big   = (!h_q.pix && (max_all > best_big_q)) ? max_all : best_big_q;
    if (new_small == new_big) begin
      result.winner  = lrfd_pkg::WIN_TIE;
      result.longest = new_small;
    end else if (new_small > new_big) begin
      result.winner  = lrfd_pkg::WIN_SMALL;
      result.longest = new_small;
    end else begin
      result.winner  = lrfd_pkg::WIN_BIG;
      result.longest = new_big;
    end
    push = valid_c_q && last_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_small_q <= '0;
      best_big_q   <= '0;
    end else if (valid_c_q) begin
      if (last_c_q) begin
        best_small_q <= '0;
        best_big_q   <= '0;
      end else begin
        best_small_q <= new_small;
        best_big_q   <= new_big;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry result queue. Input ready reserves a slot for every image end
  // already in the pipeline, so a push never meets a full queue.
  // ---------------------------------------------------------------------------
  lrfd_pkg::result_t res_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              pop;
  logic [2:0]        pending;
  lrfd_pkg::result_t head;

  assign pop     = m_axis_tvalid && m_axis_tready;
  assign pending = 3'(cnt_q) + 3'(valid_b_q && last_b_q) + 3'(valid_c_q && last_c_q);

  assign s_axis_tready = pending < 3'd2;

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q[wr_ptr_q] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head          = res_q[rd_ptr_q];
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {3'b000, head.longest, head.winner};

endmodule

@@ hdl/lrfd_checker.sv @@
// Port-level checks for longest_run_four_directions_core, bound to every instance.
// Depends on lrfd_pkg for field widths and the top level's port list.
module lrfd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lrfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic last_req;

  assign last_req = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  // A rise of result valid must trace back to an accepted last pixel of an image.
  a_result_follows_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(last_req, 3)
  ) else $error("result appeared without a matching last pixel");

  // Every result names a legal winner and a run of at least one pixel, with zero padding bits.
  a_result_legal : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'b11) && (m_axis_tdata[12:2] != 11'd0)
                      && (m_axis_tdata[15:13] == 3'b000)
  ) else $error("result holds an illegal winner or length");

  a_out_valid_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid
  ) else $error("result request withdrawn before it was taken");

  a_out_data_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)
  ) else $error("result changed while stalled");

endmodule

bind longest_run_four_directions_core lrfd_checker u_lrfd_checker (.*);

@@ tb/sv/lrfd_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for longest_run_four_directions_core: follows the pixel and config
// traffic, predicts each image result and compares it with the result stream.
// Depends on lrfd_pkg for the result layout, the widths and the winner codes.
module lrfd_result_checker #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lrfd_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic [lrfd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [0] pixel_class
  input  logic                               s_axis_tlast,   // last_pixel
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [lrfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [1:0] winner, [12:2] longest
  output int unsigned                        mismatch_cnt_o,
  output int unsigned                        pending_o
);

  typedef bit [lrfd_pkg::RUN_W-1:0] run_len_t;

  // Copy of the row above, one entry per column.
  bit       row_pix  [MAX_SIDE];
  run_len_t vert_run [MAX_SIDE];
  run_len_t diag_run [MAX_SIDE];
  run_len_t anti_run [MAX_SIDE];

  bit                         ul_pix, left_pix, top_row;
  run_len_t                   ul_run, left_run, best_small, best_big;
  int unsigned                col;
  logic [lrfd_pkg::CFG_W-1:0] side_cfg;

  lrfd_pkg::result_t longest_q [$];

  function automatic run_len_t grow(run_len_t r);
    return (r == lrfd_pkg::RUN_MAX) ? r : r + 1'b1;
  endfunction

  function automatic void clear_image();
    ul_pix     = 1'b0;
    ul_run     = '0;
    left_pix   = 1'b0;
    left_run   = '0;
    col        = 0;
    top_row    = 1'b1;
    best_small = '0;
    best_big   = '0;
  endfunction

  function automatic void track_pixel(bit p, bit last);
    int unsigned       side, c;
    run_len_t          h, v, dg, ad, peak;
    lrfd_pkg::result_t res;
    side = (side_cfg == 0) ? 1 : (side_cfg > MAX_SIDE) ? MAX_SIDE : side_cfg;
    // A side shrunk to the current column or below starts a new row.
    if (col >= side) begin
      col     = 0;
      top_row = 1'b0;
    end
    c  = col;
    h  = 1;
    v  = 1;
    dg = 1;
    ad = 1;
    if (c > 0 && left_pix == p) h = grow(left_run);
    if (!top_row) begin
      if (row_pix[c] == p) v = grow(vert_run[c]);
      if (c > 0 && ul_pix == p) dg = grow(ul_run);
      if (c + 1 < side && row_pix[c+1] == p) ad = grow(anti_run[c+1]);
    end
    ul_pix      = row_pix[c];
    ul_run      = diag_run[c];
    row_pix[c]  = p;
    vert_run[c] = v;
    diag_run[c] = dg;
    anti_run[c] = ad;
    left_pix    = p;
    left_run    = h;
    peak = h;
    if (v > peak) peak = v;
    if (dg > peak) peak = dg;
    if (ad > peak) peak = ad;
    if (p) begin
      if (peak > best_small) best_small = peak;
    end else begin
      if (peak > best_big) best_big = peak;
    end
    if (c + 1 >= side) begin
      col     = 0;
      top_row = 1'b0;
    end else begin
      col = c + 1;
    end
    if (last) begin
      if (best_small == best_big) begin
        res.winner  = lrfd_pkg::WIN_TIE;
        res.longest = best_small;
      end else if (best_small > best_big) begin
        res.winner  = lrfd_pkg::WIN_SMALL;
        res.longest = best_small;
      end else begin
        res.winner  = lrfd_pkg::WIN_BIG;
        res.longest = best_big;
      end
      longest_q = {longest_q, res};
      clear_image();
    end
  endfunction

  always @(posedge clk_i) begin
    lrfd_pkg::result_t want;
    if (!rst_ni) begin
      side_cfg = lrfd_pkg::GRID_RESET;
      clear_image();
      longest_q.delete();
    end else begin
      if (cfg_we_i) side_cfg = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (longest_q.size() == 0) begin
          $error("result with no image pending: tdata %h", m_axis_tdata);
          mismatch_cnt_o++;
        end else begin
          want = longest_q.pop_front();
          if (m_axis_tdata[1:0] !== want.winner) begin
            $error("winner: expected %0d, actual %0d", want.winner, m_axis_tdata[1:0]);
            mismatch_cnt_o++;
          end
          if (m_axis_tdata[12:2] !== want.longest) begin
            $error("longest_run: expected %0d, actual %0d", want.longest,
                   m_axis_tdata[12:2]);
            mismatch_cnt_o++;
          end
          if (m_axis_tdata[15:13] !== 3'b000) begin
            $error("tdata padding: expected 0, actual %0d", m_axis_tdata[15:13]);
            mismatch_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) track_pixel(s_axis_tdata[0], s_axis_tlast);
    end
    pending_o = longest_q.size();
  end

endmodule

@@ tb/sv/tb_longest_run_four_directions_core.sv @@
`timescale 1ns / 100ps
// Testbench top for longest_run_four_directions_core: clock, reset, pixel and config
// stimulus, a randomly stalling result sink and the final verdict.
// Depends on lrfd_pkg, the block under test and lrfd_result_checker.
module tb_longest_run_four_directions_core;

  logic                                 clk_i         = 1'b0;
  logic                                 rst_ni        = 1'b0;
  logic                                 cfg_we_i      = 1'b0;
  logic [lrfd_pkg::CFG_W-1:0]           cfg_wdata_i   = '0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [lrfd_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;  // [0] pixel_class
  logic                                 s_axis_tlast  = 1'b0; // last_pixel
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [lrfd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;         // [1:0] winner, [12:2] longest

  int unsigned mismatch_cnt;
  int unsigned pending;

  // Percentages of cycles in which the pixel source and the result sink hold off.
  int unsigned sender_gap_pct   = 0;
  int unsigned receiver_gap_pct = 0;
  // Side last written, as the top sees it, to size the images.
  int unsigned cur_side         = lrfd_pkg::GRID_RESET;
  int unsigned pixels_sent      = 0;

  longest_run_four_directions_core #(
    .MAX_SIDE(1024)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  lrfd_result_checker #(
    .MAX_SIDE(1024)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending)
  );

  always #2 clk_i = ~clk_i;

  // The result sink decides afresh on every falling edge whether it takes a request.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_gap_pct);
  end

  // Sends one pixel request and returns at the rising edge where the block accepts
  // it. At each falling edge in front of it the source holds off with the set
  // percentage. Valid stays high into the next request when no hold-off falls
  // between them.
  task automatic send_pixel(input bit p, input bit last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= lrfd_pkg::IN_TDATA_W'(p);
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
  endtask

  // Sends a fixed pattern in raster order; the leftmost bit is the first pixel.
  task automatic send_pattern(input bit [63:0] pix, input int unsigned n, input bit last);
    for (int unsigned i = 0; i < n; i++) begin
      send_pixel(pix[n-1-i], last && (i + 1 == n));
    end
  endtask

  // Sends one image of random pixels; small_pct sets the share of the small class.
  task automatic send_image(input int unsigned count, input int unsigned small_pct);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel($urandom_range(0, 99) < small_pct, i + 1 == count);
    end
  endtask

  // Stops the pixel stream until every expected result has been taken, then lets
  // the pipeline run empty. Pixels without tlast cause no result, so the extra
  // cycles let such a pixel leave the pipeline with some margin.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Writes grid_side once the block is idle; the write enable is high for one edge.
  task automatic write_side(input int unsigned v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[lrfd_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_side     = v;
  endtask

  initial begin
    int unsigned start, done, pick, eff, count, r;
    int unsigned mix [5] = '{0, 25, 50, 75, 100};

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed images run with the source idling a little and the sink a lot.
    sender_gap_pct   = 17;
    receiver_gap_pct = 60;

    // The side out of reset is 1024: a short image that never leaves row 0.
    send_pattern(64'b1101, 4, 1'b1);
    // A side of zero acts as one, so every pixel is a row: vertical run of three.
    write_side(0);
    send_pattern(64'b000, 3, 1'b1);
    // Anti-diagonal of three small pixels on a 3x3 grid.
    write_side(3);
    send_pattern(64'b001_010_100, 9, 1'b1);
    // Diagonal against anti-diagonal of equal length gives a tie.
    write_side(2);
    send_pattern(64'b10_01, 4, 1'b1);
    // Side shrunk in the middle of the second row: the next pixel wraps to column 0.
    write_side(4);
    send_pattern(64'b1100_11, 6, 1'b0);
    write_side(2);
    send_pattern(64'b011, 3, 1'b1);

    // Random images. The first third stalls mostly on the sink, the second mostly
    // on the source, the rest runs without hold-offs.
    start = pixels_sent;
    while (pixels_sent - start < 195) begin
      done = pixels_sent - start;
      if (done < 65) begin
        sender_gap_pct   = 17;
        receiver_gap_pct = 60;
      end else if (done < 130) begin
        sender_gap_pct   = 60;
        receiver_gap_pct = 17;
      end else begin
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
      end

      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        // Mostly small grids, now and then zero or a value past the widest grid.
        r = $urandom_range(0, 99);
        if (r < 70) write_side($urandom_range(1, 6));
        else if (r < 88) write_side($urandom_range(7, 20));
        else if (r < 94) write_side(0);
        else write_side($urandom_range(1025, 2047));
      end else if (pick == 3) begin
        drain_results();
      end

      eff = (cur_side == 0) ? 1 : (cur_side > 1024) ? 1024 : cur_side;
      if (eff > 20) begin
        // Wide grids get short images that end within the first row.
        count = $urandom_range(1, 40);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6) count = eff * eff;
        else if (r < 8) count = $urandom_range(1, eff * eff);
        else count = eff * eff + eff * $urandom_range(1, 3) + $urandom_range(0, eff - 1);
      end
      if (count > 195 - done) count = 195 - done;
      send_image(count, mix[$urandom_range(0, 4)]);
    end

    // All register bits set: clamps to the widest grid, one full row of big pixels
    // and two pixels of the next one.
    write_side(2047);
    send_image(1026, 0);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_longest_run_four_directions_core OK");
    end else begin
      $display("tb_longest_run_four_directions_core NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("tb_longest_run_four_directions_core NOT OK");
    $finish;
  end

endmodule

@@ longest_run_four_directions_core.f @@
hdl/lrfd_pkg.sv
hdl/lrfd_cell.sv
hdl/lrfd_line_buf.sv
hdl/longest_run_four_directions_core.sv
hdl/lrfd_checker.sv
tb/sv/lrfd_result_checker.sv
tb/sv/tb_longest_run_four_directions_core.sv
